[design/fpa_pkg.sv]
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 8;
    // numerator 2*(|a| << F) + |b| fits in NW bits
    localparam int NW        = DW + FRAC_BITS + 2;
    localparam int RW        = DW + 1;
    localparam int QDEPTH    = 2;

    typedef enum logic [3:0] {
        K_ADD = 4'd0, K_SUB = 4'd1, K_MUL = 4'd2, K_DIV = 4'd3,
        K_GT  = 4'd4, K_LT  = 4'd5, K_GE  = 4'd6, K_LE  = 4'd7,
        K_EQ  = 4'd8, K_NE  = 4'd9, K_MIN = 4'd10, K_MAX = 4'd11,
        K_INC = 4'd12, K_DEC = 4'd13, K_TOI = 4'd14, K_NOP = 4'd15
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
        logic [DW-1:0]   mag_a;
        logic [DW-1:0]   mag_b;
        logic            neg;
        logic            dz;
    } item_t;

    typedef struct packed {
        kind_t           kind;
        logic            neg;
        logic            dz;
        logic            flag;
        logic [DW-1:0]   res;
    } ctl_t;

    typedef struct packed {
        logic [RW-1:0]   r;
        logic [NW-1:0]   n;
        logic [DW-1:0]   q;
    } div_t;

endpackage

[design/fixed_point_alu_q24_8_top.sv]
`timescale 1ns / 1ps
// Signed Q24.8 fixed-point ALU. An item (kind, operand_a, operand_b) is taken
// at a clock edge with start high and busy low; one item can be taken every
// cycle. Each item yields one result, shown for a single cycle with done high,
// in issue order, once it has passed the queue, stage A and the divider pipe,
// which resolves one quotient bit per pipeline stage. The receiver cannot
// stall, so nothing backs up.
module fixed_point_alu_q24_8_top import fpa_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [3:0]    kind,
    input  logic [DW-1:0] operand_a,
    input  logic [DW-1:0] operand_b,
    output logic          done,
    output logic [DW-1:0] result,
    output logic          flag,
    output logic          div_zero
);

    item_t  f_item;
    item_t  q_item;
    logic   q_full;
    logic   q_empty;

    // front: operand magnitudes, sign and zero-divisor classification
    fpa_front u_front (
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .item      (f_item)
    );

    // short queue between front and back; the back drains one item a cycle
    fpa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (start && !q_full),
        .wdata (f_item),
        .full  (q_full),
        .pop   (!q_empty),
        .empty (q_empty),
        .rdata (q_item)
    );

    assign busy = q_full;

    // back: execution pipeline, equal latency for every kind keeps order
    fpa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_item  (q_item),
        .done     (done),
        .result   (result),
        .flag     (flag),
        .div_zero (div_zero)
    );

endmodule

[design/fpa_front.sv]
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; (
    input  logic [3:0]    kind,
    input  logic [DW-1:0] operand_a,
    input  logic [DW-1:0] operand_b,
    output item_t         item
);

    always_comb
    begin
        item.kind  = kind_t'(kind);
        item.a     = operand_a;
        item.b     = operand_b;
        item.mag_a = operand_a[DW-1] ? (~operand_a + 1'b1) : operand_a;
        item.mag_b = operand_b[DW-1] ? (~operand_b + 1'b1) : operand_b;
        item.neg   = operand_a[DW-1] ^ operand_b[DW-1];
        item.dz    = (kind_t'(kind) == K_DIV) && (operand_b == '0);
    end

endmodule

[design/fpa_queue.sv]
`timescale 1ns / 1ps
module fpa_queue import fpa_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t rdata
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    item_t          mem_reg [QDEPTH];
    logic [AW-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]    cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == AW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == AW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

[design/fpa_back.sv]
`timescale 1ns / 1ps
module fpa_back import fpa_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  item_t         in_item,
    output logic          done,
    output logic [DW-1:0] result,
    output logic          flag,
    output logic          div_zero
);

    // one restoring step: one quotient bit
    function automatic div_t div_step(input div_t s, input logic [RW-1:0] d);
        logic [RW:0] t;
        div_t        o;
        t   = {s.r, s.n[NW-1]};
        o.n = {s.n[NW-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            o.r = RW'(t - {1'b0, d});
            o.q = {s.q[DW-2:0], 1'b1};
        end
        else
        begin
            o.r = t[RW-1:0];
            o.q = {s.q[DW-2:0], 1'b0};
        end
        return o;
    endfunction

    // stage A: product, simple ops, divider setup
    logic               va_reg;
    ctl_t               ca_reg, ca_next;
    logic [2*DW-1:0]    pa_reg;
    logic [RW-1:0]      da_reg;
    logic [NW-1:0]      na_reg;

    // divider pipe
    logic               v_reg [NW+1];
    ctl_t               c_reg [NW+1];
    div_t               s_reg [NW+1];
    logic [RW-1:0]      d_reg [NW+1];

    logic signed [DW-1:0] sa, sb;
    logic [2*DW-1:0]      rnd;
    logic [DW-1:0]        mres;
    ctl_t                 cm;
    ctl_t                 cl;
    logic [DW-1:0]        ql;

    assign sa = $signed(in_item.a);
    assign sb = $signed(in_item.b);

    always_comb
    begin
        ca_next      = '0;
        ca_next.kind = in_item.kind;
        ca_next.neg  = in_item.neg;
        ca_next.dz   = in_item.dz;
        case (in_item.kind)
            K_ADD:   ca_next.res = in_item.a + in_item.b;
            K_SUB:   ca_next.res = in_item.a - in_item.b;
            K_GT:    ca_next.flag = sa > sb;
            K_LT:    ca_next.flag = sa < sb;
            K_GE:    ca_next.flag = sa >= sb;
            K_LE:    ca_next.flag = sa <= sb;
            K_EQ:    ca_next.flag = sa == sb;
            K_NE:    ca_next.flag = sa != sb;
            K_MIN:   ca_next.res = (sa < sb) ? in_item.a : in_item.b;
            K_MAX:   ca_next.res = (sa > sb) ? in_item.a : in_item.b;
            K_INC:   ca_next.res = in_item.a + 1'b1;
            K_DEC:   ca_next.res = in_item.a - 1'b1;
            K_TOI:   ca_next.res = DW'(sa >>> FRAC_BITS);
            default: ca_next.res = '0;
        endcase
    end

    // multiply rounding, half away from zero on the magnitude
    always_comb
    begin
        rnd  = pa_reg + ((2*DW)'(1) << (FRAC_BITS - 1));
        mres = rnd[FRAC_BITS +: DW];
        cm   = ca_reg;
        if (ca_reg.kind == K_MUL)
        begin
            cm.res = ca_reg.neg ? (~mres + 1'b1) : mres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            for (int i = 0; i <= NW; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            va_reg   <= in_valid;
            v_reg[0] <= va_reg;
            for (int i = 0; i < NW; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg <= ca_next;
        pa_reg <= in_item.mag_a * in_item.mag_b;
        da_reg <= {in_item.mag_b, 1'b0};
        na_reg <= {1'b0, in_item.mag_a, {FRAC_BITS{1'b0}}, 1'b0}
                  + NW'(in_item.mag_b);
        c_reg[0]   <= cm;
        d_reg[0]   <= da_reg;
        s_reg[0].r <= '0;
        s_reg[0].n <= na_reg;
        s_reg[0].q <= '0;
        for (int i = 0; i < NW; i++)
        begin
            c_reg[i+1] <= c_reg[i];
            d_reg[i+1] <= d_reg[i];
            s_reg[i+1] <= div_step(s_reg[i], d_reg[i]);
        end
    end

    assign cl = c_reg[NW];
    assign ql = s_reg[NW].q;

    always_comb
    begin
        done     = v_reg[NW];
        flag     = cl.flag;
        div_zero = cl.dz;
        if (cl.kind == K_DIV)
        begin
            result = cl.dz ? '0 : (cl.neg ? (~ql + 1'b1) : ql);
        end
        else
        begin
            result = cl.res;
        end
    end

endmodule
